/* sv/vpd_pkg.sv */
// ----------------------------------------------------------------------------
// vpd_pkg: shared constants, types and compare functions
// Table geometry, the request and link structs that run between the control
// and the cells, and IEEE single equality on raw bit patterns.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_CELLS   = 8;
  localparam int CELL_W      = $clog2(NUM_CELLS);
  localparam int ROWS        = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int REM_W       = (CNT_W > CELL_W + 1) ? CNT_W : CELL_W + 1;
  localparam int COMP_W      = 32;
  localparam int NUM_COMP    = 4;
  localparam int KEY_W       = COMP_W * NUM_COMP;
  localparam int OUT_IDX_W   = 10;

  localparam logic [COMP_W-2:0] INF_MAG = 31'h7F80_0000;

  // Broadcast from the control to every cell in the row.
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [REM_W-1:0] remaining;  // entries still to be searched, this row on
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [CELL_W-1:0] wr_lane;
  } req_t;

  // Priority link handed from one cell to the next.
  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] sel;
  } link_t;

  typedef struct packed {
    logic             is_new;
    logic             overflow;
    logic [IDX_W-1:0] index;
  } res_t;

  function automatic logic comp_eq(input logic [COMP_W-1:0] a,
                                   input logic [COMP_W-1:0] b);
    logic [COMP_W-2:0] ma;
    logic [COMP_W-2:0] mb;
    logic              eq;
    ma = a[COMP_W-2:0];
    mb = b[COMP_W-2:0];
    if (ma > INF_MAG || mb > INF_MAG) begin
      eq = 1'b0;
    end else if (ma == '0 && mb == '0) begin
      eq = 1'b1;
    end else begin
      eq = (a == b);
    end
    return eq;
  endfunction

  function automatic logic key_eq(input logic [KEY_W-1:0] a,
                                  input logic [KEY_W-1:0] b);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < NUM_COMP; i++) begin
      eq = eq & comp_eq(a[i*COMP_W +: COMP_W], b[i*COMP_W +: COMP_W]);
    end
    return eq;
  endfunction

endpackage

/* sv/vpd_cell.sv */
// ----------------------------------------------------------------------------
// vpd_cell: one lane of the position table
// Holds every entry whose id is congruent to its lane number, compares one
// stored row against the query per cycle and joins the priority link.
// ----------------------------------------------------------------------------
module vpd_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vpd_pkg::CELL_W-1:0]  lane_id,
  input  vpd_pkg::req_t               req,
  input  logic [vpd_pkg::KEY_W-1:0]   key,
  input  vpd_pkg::link_t              link_in,
  output vpd_pkg::link_t              link_out,
  output logic                        hit
);

  logic [vpd_pkg::KEY_W-1:0] mem [vpd_pkg::ROWS];
  logic [vpd_pkg::KEY_W-1:0] rdata;
  logic                      rvalid;
  logic                      lane_live;

  // The lane holds a live entry in this row when it lies below the count.
  assign lane_live = vpd_pkg::REM_W'(lane_id) < req.remaining;

  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_lane == lane_id) begin
      mem[req.wr_row] <= key;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      hit    <= 1'b0;
    end else begin
      rvalid <= req.rd_en && lane_live;
      hit    <= rvalid && vpd_pkg::key_eq(rdata, key);
    end
  end

  // Lower lanes win, so the first match in a row keeps its place.
  assign link_out.found = link_in.found | hit;
  assign link_out.sel   = link_in.found ? link_in.sel : lane_id;

endmodule

/* sv/vpd_ctrl.sv */
// ----------------------------------------------------------------------------
// vpd_ctrl: search sequencer
// Holds the query and entry count, steps the cells through the stored rows,
// and decides hit, insert or overflow for each word.
// ----------------------------------------------------------------------------
module vpd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic                       in_start,
  input  logic [vpd_pkg::KEY_W-1:0]  in_key,
  output logic                       in_ready,
  input  vpd_pkg::link_t             chain,
  input  logic                       out_free,
  output vpd_pkg::req_t              req,
  output logic [vpd_pkg::KEY_W-1:0]  key,
  output logic                       res_valid,
  output vpd_pkg::res_t              res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                     state;
  logic [vpd_pkg::CNT_W-1:0]  count;
  logic [vpd_pkg::REM_W-1:0]  remaining;
  logic [vpd_pkg::ROW_W-1:0]  row;
  logic                       p1_v;
  logic                       p2_v;
  logic [vpd_pkg::ROW_W-1:0]  p1_row;
  logic [vpd_pkg::ROW_W-1:0]  p2_row;
  logic                       hit_now;
  logic                       miss_now;
  logic                       issue;
  logic                       full;
  logic [vpd_pkg::REM_W-1:0]  remaining_next;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign full      = (count == vpd_pkg::CNT_W'(vpd_pkg::TABLE_DEPTH));

  // A match shows when its row read reaches p2, the stage of the cells' hit
  // register. A miss is known when every row was read and nothing is in flight.
  assign hit_now  = (state == S_SCAN) && p2_v && chain.found;
  assign issue    = (state == S_SCAN) && !hit_now && (remaining != '0);
  assign miss_now = (state == S_SCAN) && !hit_now && (remaining == '0) && !p1_v && !p2_v;

  assign remaining_next = (remaining > vpd_pkg::REM_W'(vpd_pkg::NUM_CELLS))
                        ? remaining - vpd_pkg::REM_W'(vpd_pkg::NUM_CELLS) : '0;

  assign req.rd_en     = issue;
  assign req.rd_row    = row;
  assign req.remaining = remaining;
  assign req.wr_en     = miss_now && !full;
  assign req.wr_row    = vpd_pkg::ROW_W'(count >> vpd_pkg::CELL_W);
  assign req.wr_lane   = vpd_pkg::CELL_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_start) begin
              count <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now || miss_now) begin
            if (miss_now && !full) begin
              count <= count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_row <= row;
    p2_row <= p1_row;
    if (in_fire) begin
      key       <= in_key;
      row       <= '0;
      remaining <= in_start ? '0 : vpd_pkg::REM_W'(count);
    end else if (issue) begin
      row       <= vpd_pkg::ROW_W'(row + 1'b1);
      remaining <= remaining_next;
    end
    if (hit_now) begin
      res.is_new   <= 1'b0;
      res.overflow <= 1'b0;
      res.index    <= vpd_pkg::IDX_W'({p2_row, chain.sel});
    end else if (miss_now) begin
      res.is_new   <= !full;
      res.overflow <= full;
      res.index    <= full ? '0 : vpd_pkg::IDX_W'(count);
    end
  end

endmodule

/* sv/vertex_position_dedup.sv */
// ----------------------------------------------------------------------------
// vertex_position_dedup: vertex welding by position
// A miss sweeps every stored row, R = ceil(N / 8) rows for N stored entries,
// before its result word is presented; a hit ends the sweep. The next input
// word is taken only after the result is handed over to the output register,
// so one word is searched at a time. The eight cells read one row each cycle.
// Reset empties the table at once by clearing the entry count; no sweep runs.
// ----------------------------------------------------------------------------
module vertex_position_dedup (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64], pos_w[127:96]
  input  logic [0:0]   s_axis_tuser,   // start_of_list[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // new_index[9:0], zero fill[15:10]
  output logic [1:0]   m_axis_tuser    // is_new[0], overflow[1]
);

  localparam int OUT_PAD_W = 16 - vpd_pkg::OUT_IDX_W;

  // The table is split into eight lanes: entry i lives in lane i mod 8 at row
  // i / 8. Each scan cycle the sequencer reads one row in all lanes; each lane
  // compares its entry with the query and the priority link through the
  // lanes picks the lowest matching lane, so ids come out in first-seen order.
  vpd_pkg::req_t                req;
  vpd_pkg::res_t                res;
  vpd_pkg::link_t               links [vpd_pkg::NUM_CELLS+1];
  logic [vpd_pkg::NUM_CELLS-1:0] hit_vec;
  logic [vpd_pkg::KEY_W-1:0]    key;
  logic                         res_valid;
  logic                         out_free;
  logic                         in_fire;
  logic [vpd_pkg::OUT_IDX_W-1:0] out_index;
  logic                         out_new;
  logic                         out_ovf;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  // The output register frees when empty or when its word is being taken, so
  // a new word can be accepted while a finished result still waits.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  vpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_start  (s_axis_tuser[0]),
    .in_key    (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .chain     (links[vpd_pkg::NUM_CELLS]),
    .out_free  (out_free),
    .req       (req),
    .key       (key),
    .res_valid (res_valid),
    .res       (res)
  );

  assign links[0] = '0;

  for (genvar g = 0; g < vpd_pkg::NUM_CELLS; g++) begin : g_cell
    vpd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_id  (vpd_pkg::CELL_W'(g)),
      .req      (req),
      .key      (key),
      .link_in  (links[g]),
      .link_out (links[g+1]),
      .hit      (hit_vec[g])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_index <= vpd_pkg::OUT_IDX_W'(res.index);
      out_new   <= res.is_new;
      out_ovf   <= res.overflow;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_index};
  assign m_axis_tuser = {out_ovf, out_new};

  // Stored positions are pairwise unequal, so at most one lane can match.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one lane matched the query");

  // One word in flight: the input closes right after each accepted word.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while a word was still being searched");

  // An overflow result carries id zero and is never marked as new.
  a_overflow_word: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("overflow word with nonzero id or new flag");

  // A result handed over is valid in the output register from the next cycle on.
  a_result_taken: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_free) |=> m_axis_tvalid)
    else $error("finished result did not reach the output register");

endmodule
